>>> sv/pfip_pkg.sv
`timescale 1ns / 1ps
// shared constants and register codes for the frame-to-pixel converter
package pfip_pkg;

	localparam int MAX_ROW_BYTES = 512;
	localparam int PLANE_COUNT   = 4;
	localparam int STORED_PLANES = PLANE_COUNT - 1;
	localparam int SEG_MAX       = MAX_ROW_BYTES / PLANE_COUNT;
	localparam int SEG_AW        = $clog2(SEG_MAX);
	localparam int SEG_W         = $clog2(SEG_MAX + 1);
	localparam int PLANE_W       = $clog2(PLANE_COUNT);

	localparam int BYTE_W   = 8;
	localparam int ROWB_W   = 10;
	localparam int ROWC_W   = 8;
	localparam int BCOL_W   = 9;
	localparam int INDEX_W  = 4;
	localparam int PCOL_W   = 11;
	localparam int CFG_W    = 10;
	localparam int CFG_AW   = 2;
	localparam int RUN_W    = 3;

	localparam logic [ROWB_W-1:0] ROW_BYTES_RST = ROWB_W'(8);
	localparam logic [ROWC_W-1:0] ROW_COUNT_RST = ROWC_W'(8);

	typedef enum logic [CFG_AW-1:0] {
		REG_PACKED_MODE = 2'd0,
		REG_ROW_BYTES   = 2'd1,
		REG_ROW_COUNT   = 2'd2
	} reg_index_t;

	localparam logic [PLANE_W-1:0] LAST_PLANE = PLANE_W'(PLANE_COUNT - 1);
	localparam logic [RUN_W-1:0]   RUN_PLANAR = RUN_W'(7);
	localparam logic [RUN_W-1:0]   RUN_PACKED = RUN_W'(3);

endpackage

>>> sv/planar_or_packed_frame_to_indexed_pixels_core.sv
`timescale 1ns / 1ps
// frame byte stream to indexed pixels: planar row store and pixel serializer
//
// Bytes arrive one per item and pixels leave one per item, each tagged with its column
// and row. A byte that is only stored (planes 0 to 2 of a planar row) is never stalled
// and never waits on the output. A byte that produces pixels passes one register
// stage, where the row store is read, and then a serializer that puts out one pixel per
// cycle while out_stall is low: 8 pixels for a plane 3 byte, 4 for a packed byte, while
// the next byte is already taken. The pixel serializer sets the sustained byte rate,
// which is higher in planar mode than in packed mode. The row store is one memory of
// MAX_ROW_BYTES/4 entries, each holding the three stored plane bytes of one position,
// written one lane at a time and read once per plane 3 byte. It needs no clearing.
// Writing packed_mode or row_bytes restarts the frame.
module planar_or_packed_frame_to_indexed_pixels_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [pfip_pkg::CFG_AW-1:0]       cfg_index,
	input  logic [pfip_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [pfip_pkg::BYTE_W-1:0]       byte_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [pfip_pkg::INDEX_W-1:0]      pixel_index,
	output logic [pfip_pkg::PCOL_W-1:0]       pixel_column,
	output logic [pfip_pkg::ROWC_W-1:0]       pixel_row,
	output logic                              last_of_run,
	output logic                              frame_done
);

	// configuration
	logic                            packed_q;
	logic [pfip_pkg::ROWB_W-1:0]     row_bytes_q;
	logic [pfip_pkg::ROWC_W-1:0]     row_count_q;

	// position counters
	logic [pfip_pkg::BCOL_W-1:0]     col_q;
	logic [pfip_pkg::SEG_AW-1:0]     off_q;
	logic [pfip_pkg::PLANE_W-1:0]    plane_q;
	logic [pfip_pkg::ROWC_W-1:0]     row_q;

	// row store
	logic [pfip_pkg::STORED_PLANES-1:0][pfip_pkg::BYTE_W-1:0] mem_q [pfip_pkg::SEG_MAX];

	// stage 1
	logic                                                     valid_s1;
	logic                                                     packed_s1;
	logic [pfip_pkg::BYTE_W-1:0]                              byte_s1;
	logic [pfip_pkg::STORED_PLANES-1:0][pfip_pkg::BYTE_W-1:0] rd_s1;
	logic [pfip_pkg::PCOL_W-1:0]                              pcol_s1;
	logic [pfip_pkg::ROWC_W-1:0]                              row_s1;
	logic                                                     fend_s1;

	// stage 2 serializer
	logic                                                     valid_s2;
	logic                                                     packed_s2;
	logic [pfip_pkg::RUN_W-1:0]                               cnt_s2;
	logic [pfip_pkg::BYTE_W-1:0]                              byte_s2;
	logic [pfip_pkg::STORED_PLANES-1:0][pfip_pkg::BYTE_W-1:0] pl_s2;
	logic [pfip_pkg::PCOL_W-1:0]                              pcol_s2;
	logic [pfip_pkg::ROWC_W-1:0]                              row_s2;
	logic                                                     fend_s2;

	logic [pfip_pkg::ROWB_W-1:0]     rb_eff;
	logic [pfip_pkg::SEG_W-1:0]      seg_eff;
	logic [pfip_pkg::ROWC_W-1:0]     rc_eff;
	logic                            emits;
	logic                            seg_end;
	logic                            row_end;
	logic                            frame_end;
	logic                            accept;
	logic                            s2_done;
	logic                            s1_move;
	logic                            store_wr;
	logic                            geom_wr;
	logic [pfip_pkg::PCOL_W-1:0]     pcol_start;

	always_comb begin
		if (row_bytes_q == '0) begin
			rb_eff = pfip_pkg::ROWB_W'(1);
		end else if (row_bytes_q > pfip_pkg::ROWB_W'(pfip_pkg::MAX_ROW_BYTES)) begin
			rb_eff = pfip_pkg::ROWB_W'(pfip_pkg::MAX_ROW_BYTES);
		end else begin
			rb_eff = row_bytes_q;
		end
		seg_eff = pfip_pkg::SEG_W'(rb_eff >> pfip_pkg::PLANE_W);
		if (seg_eff == '0) begin
			seg_eff = pfip_pkg::SEG_W'(1);
		end
		rc_eff = (row_count_q == '0) ? pfip_pkg::ROWC_W'(1) : row_count_q;
	end

	assign emits   = packed_q || (plane_q == pfip_pkg::LAST_PLANE);
	assign seg_end = ({1'b0, off_q} + pfip_pkg::SEG_W'(1)) >= seg_eff;
	assign row_end = packed_q
		? (({1'b0, col_q} + pfip_pkg::ROWB_W'(1)) >= rb_eff)
		: (seg_end && (plane_q == pfip_pkg::LAST_PLANE));
	assign frame_end = row_end
		&& (({1'b0, row_q} + (pfip_pkg::ROWC_W + 1)'(1)) >= {1'b0, rc_eff});

	assign s2_done  = !valid_s2 || ((cnt_s2 == '0) && !out_stall);
	assign s1_move  = valid_s1 && s2_done;
	assign in_stall = emits && valid_s1 && !s2_done;
	assign accept   = in_valid && !in_stall;
	assign store_wr = accept && !emits;
	assign geom_wr  = cfg_write && ((cfg_index == pfip_pkg::REG_PACKED_MODE)
		|| (cfg_index == pfip_pkg::REG_ROW_BYTES));

	assign pcol_start = packed_q
		? {col_q, 2'b00}
		: pfip_pkg::PCOL_W'({off_q, 3'b000});

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packed_q    <= 1'b0;
			row_bytes_q <= pfip_pkg::ROW_BYTES_RST;
			row_count_q <= pfip_pkg::ROW_COUNT_RST;
			col_q       <= '0;
			off_q       <= '0;
			plane_q     <= '0;
			row_q       <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			cnt_s2      <= '0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					pfip_pkg::REG_PACKED_MODE: packed_q <= cfg_data[0];
					pfip_pkg::REG_ROW_BYTES:   row_bytes_q <= cfg_data[pfip_pkg::ROWB_W-1:0];
					pfip_pkg::REG_ROW_COUNT:   row_count_q <= cfg_data[pfip_pkg::ROWC_W-1:0];
					default: ;
				endcase
			end
			if (geom_wr) begin
				col_q   <= '0;
				off_q   <= '0;
				plane_q <= '0;
				row_q   <= '0;
			end else if (accept) begin
				if (packed_q) begin
					col_q <= row_end ? '0 : col_q + pfip_pkg::BCOL_W'(1);
				end else begin
					off_q   <= seg_end ? '0 : off_q + pfip_pkg::SEG_AW'(1);
					plane_q <= seg_end ? plane_q + pfip_pkg::PLANE_W'(1) : plane_q;
				end
				if (row_end) begin
					row_q <= frame_end ? '0 : row_q + pfip_pkg::ROWC_W'(1);
				end
			end

			if (accept && emits) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end

			if (s1_move) begin
				valid_s2 <= 1'b1;
				cnt_s2   <= packed_s1 ? pfip_pkg::RUN_PACKED : pfip_pkg::RUN_PLANAR;
			end else if (valid_s2 && !out_stall) begin
				if (cnt_s2 == '0) begin
					valid_s2 <= 1'b0;
				end else begin
					cnt_s2 <= cnt_s2 - pfip_pkg::RUN_W'(1);
				end
			end
		end
	end

	// row store and datapath
	always_ff @(posedge clk) begin
		if (store_wr) begin
			mem_q[off_q][plane_q] <= byte_value;
		end
		if (accept && emits) begin
			rd_s1     <= mem_q[off_q];
			packed_s1 <= packed_q;
			byte_s1   <= byte_value;
			pcol_s1   <= pcol_start;
			row_s1    <= row_q;
			fend_s1   <= frame_end;
		end
		if (s1_move) begin
			packed_s2 <= packed_s1;
			byte_s2   <= byte_s1;
			pl_s2     <= rd_s1;
			pcol_s2   <= pcol_s1;
			row_s2    <= row_s1;
			fend_s2   <= fend_s1;
		end else if (valid_s2 && !out_stall) begin
			pcol_s2 <= pcol_s2 + pfip_pkg::PCOL_W'(1);
			if (packed_s2) begin
				byte_s2 <= byte_s2 << 2;
			end else begin
				byte_s2 <= byte_s2 << 1;
				for (int p = 0; p < pfip_pkg::STORED_PLANES; p++) begin
					pl_s2[p] <= pl_s2[p] << 1;
				end
			end
		end
	end

	always_comb begin
		if (packed_s2) begin
			pixel_index = {2'b00, byte_s2[7:6]};
		end else begin
			pixel_index = {byte_s2[7], pl_s2[2][7], pl_s2[1][7], pl_s2[0][7]};
		end
	end

	assign out_valid    = valid_s2;
	assign pixel_column = pcol_s2;
	assign pixel_row    = row_s2;
	assign last_of_run  = (cnt_s2 == '0);
	assign frame_done   = (cnt_s2 == '0) && fend_s2;

endmodule

>>> sv/pfip_checker.sv
`timescale 1ns / 1ps
// port-level checks for the frame-to-pixel converter, bound to the top level
module pfip_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [pfip_pkg::PCOL_W-1:0]       pixel_column,
	input logic [pfip_pkg::ROWC_W-1:0]       pixel_row,
	input logic                              last_of_run,
	input logic                              frame_done
);

	// stalled item stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_column))
		else $error("output item dropped while stalled");

	// frame end only on the last pixel of a byte
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_done |-> last_of_run)
		else $error("frame_done without last_of_run");

	// pixels of one byte come without gaps
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid)
		else $error("gap inside a pixel run");

	// columns step by one inside a run, on the same row
	a_run_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=>
		(pixel_column == pfip_pkg::PCOL_W'($past(pixel_column) + 1'b1))
		&& (pixel_row == $past(pixel_row)))
		else $error("column or row jump inside a pixel run");

endmodule

bind planar_or_packed_frame_to_indexed_pixels_core pfip_checker u_pfip_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.pixel_column (pixel_column),
	.pixel_row    (pixel_row),
	.last_of_run  (last_of_run),
	.frame_done   (frame_done)
);
